### sv/arc_pkg.sv
// Package with shared types, constants and helpers of the ASCII radix converter.
`timescale 1ns / 1ps

package arc_pkg;

	// Accumulator and digit buffer sizes
	localparam int VALUE_BITS  = 32;
	localparam int DIGIT_DEPTH = 32;
	localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
	localparam int BIT_CNT_W   = $clog2(VALUE_BITS);

	localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;
	localparam logic [VALUE_BITS-1:0] DEC_LIMIT = VALUE_MAX / 10;

	// Configuration port
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_RADIX = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TARGET_RADIX = 1'd1;

	// Radix codes; code three behaves as hexadecimal
	localparam logic [1:0] RADIX_HEX = 2'd0;
	localparam logic [1:0] RADIX_DEC = 2'd1;
	localparam logic [1:0] RADIX_BIN = 2'd2;

	// ASCII characters
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A_LOW = 8'h61;
	localparam logic [7:0] CH_F_LOW = 8'h66;

	typedef struct packed {
		logic [7:0] digit_char;
		logic       final_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
		logic       overflowed;
	} out_item_t;

	// Digit generator to digit buffer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [3:0]        digit;
		logic              done;
	} gen_status_t;

	typedef enum logic [1:0] {
		ST_ACCUM,
		ST_DIVIDE,
		ST_EMIT
	} conv_state_t;

	// Map a digit value to its lower-case ASCII glyph
	function automatic logic [7:0] glyph(input logic [3:0] d);
		logic [7:0] g;
		if (d < 4'd10) begin
			g = CH_ZERO + {4'b0000, d};
		end else begin
			g = CH_A_LOW + {4'b0000, d} - 8'd10;
		end
		return g;
	endfunction

endpackage

### sv/ascii_radix_converter_top.sv
// Top level of the ASCII radix converter: configuration, control and datapath.
`timescale 1ns / 1ps

// Accumulates ASCII digits in the source radix into a 32-bit value, one input
// transaction per cycle while in_stall is low; the scale-and-add is a combinational
// shift-add step. The transaction marked final_char starts conversion and
// in_stall stays high until the last output digit is taken. Conversion to
// decimal uses a bit-serial divider (up to 10 digits). Hexadecimal and binary
// produce one digit per cycle. Digits then leave the digit buffer through a
// registered memory read, one read in flight at a time, most significant
// first, each output transaction carrying the wrap flag of the number.

module ascii_radix_converter_top import arc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_item_t               in_data,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_item_t              out_data
);

	logic [1:0]            source_radix_q;
	logic [1:0]            target_radix_q;
	conv_state_t           state_q;
	conv_state_t           state_nxt;
	logic                  in_take;
	logic                  start;
	logic                  last_taken;
	logic [VALUE_BITS-1:0] next_value;
	logic                  next_wrap;
	logic                  ovf_q;
	gen_status_t           status;

	assign in_take    = in_valid && !in_stall;
	assign start      = in_take && in_data.final_char;
	assign last_taken = out_valid && !out_stall && out_data.out_last;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_radix_q <= RADIX_HEX;
			target_radix_q <= RADIX_DEC;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOURCE_RADIX: source_radix_q <= cfg_data;
				REG_TARGET_RADIX: target_radix_q <= cfg_data;
			endcase
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_ACCUM:  if (start) state_nxt = ST_DIVIDE;
			ST_DIVIDE: if (status.done) state_nxt = ST_EMIT;
			ST_EMIT:   if (last_taken) state_nxt = ST_ACCUM;
			default:   state_nxt = ST_ACCUM;
		endcase
	end

	// Outputs of the state machine
	always_comb begin
		unique case (state_q)
			ST_ACCUM: in_stall = 1'b0;
			default:  in_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Capture the wrap flag of the number being converted
	always_ff @(posedge clk) begin
		if (start) begin
			ovf_q <= next_wrap;
		end
	end

	arc_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (in_take),
		.ch         (in_data.digit_char),
		.fin        (in_data.final_char),
		.radix      (source_radix_q),
		.next_value (next_value),
		.next_wrap  (next_wrap)
	);

	arc_digit_gen u_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.start_value (next_value),
		.radix       (target_radix_q),
		.status      (status)
	);

	arc_digit_buf u_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.status    (status),
		.ovf       (ovf_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### sv/arc_accum.sv
// Character accumulator: value = value * radix + digit with sticky wrap flag.
`timescale 1ns / 1ps

module arc_accum import arc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic [7:0]            ch,
	input  logic                  fin,
	input  logic [1:0]            radix,
	output logic [VALUE_BITS-1:0] next_value,
	output logic                  next_wrap
);

	logic [VALUE_BITS-1:0] value_q;
	logic                  wrap_q;
	logic [VALUE_BITS-1:0] prod;
	logic                  mul_ovf;
	logic signed [8:0]     addend;
	logic [VALUE_BITS+1:0] sum;

	// Scale by the radix and decode the character
	always_comb begin
		addend = 9'sd0;
		unique case (radix)
			RADIX_DEC: begin
				mul_ovf = value_q > DEC_LIMIT;
				prod    = (value_q << 3) + (value_q << 1);
				addend  = $signed({1'b0, ch}) - 9'sd48;
			end
			RADIX_BIN: begin
				mul_ovf = value_q[VALUE_BITS-1];
				prod    = value_q << 1;
				addend  = (ch == CH_ONE) ? 9'sd1 : 9'sd0;
			end
			default: begin
				mul_ovf = |value_q[VALUE_BITS-1:VALUE_BITS-4];
				prod    = value_q << 4;
				if (ch >= CH_ZERO && ch <= CH_NINE) begin
					addend = $signed({1'b0, ch - CH_ZERO});
				end else if (ch >= CH_A_LOW && ch <= CH_F_LOW) begin
					addend = $signed({1'b0, ch - CH_A_LOW + 8'd10});
				end
			end
		endcase
		sum        = {2'b00, prod} + {{(VALUE_BITS-7){addend[8]}}, addend};
		next_value = sum[VALUE_BITS-1:0];
		next_wrap  = wrap_q | mul_ovf | (sum[VALUE_BITS+1:VALUE_BITS] != 2'b00);
	end

	// Advance on each character, clear after the final one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= '0;
			wrap_q  <= 1'b0;
		end else if (en) begin
			if (fin) begin
				value_q <= '0;
				wrap_q  <= 1'b0;
			end else begin
				value_q <= next_value;
				wrap_q  <= next_wrap;
			end
		end
	end

endmodule

### sv/arc_digit_gen.sv
// Digit generator: bit-serial division by ten, digit shifts for hex and binary.
`timescale 1ns / 1ps

module arc_digit_gen import arc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] start_value,
	input  logic [1:0]            radix,
	output gen_status_t           status
);

	localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(VALUE_BITS - 1);
	localparam logic [ADDR_W-1:0]    ADDR_LAST = ADDR_W'(DIGIT_DEPTH - 1);

	logic [VALUE_BITS-1:0] work_q;
	logic [3:0]            rem_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [ADDR_W-1:0]     addr_q;
	logic                  busy_q;
	logic [1:0]            radix_q;

	logic [4:0]            rem_ext;
	logic                  rem_ge;
	logic [3:0]            rem_nxt;
	logic [VALUE_BITS-1:0] quot;
	logic [3:0]            digit;
	logic                  fire;
	logic                  more;

	// One restoring step per cycle in decimal, one digit per cycle otherwise
	always_comb begin
		rem_ext = {rem_q, work_q[VALUE_BITS-1]};
		rem_ge  = rem_ext >= 5'd10;
		rem_nxt = rem_ge ? 4'(rem_ext - 5'd10) : rem_ext[3:0];
		unique case (radix_q)
			RADIX_DEC: begin
				digit = rem_nxt;
				quot  = {work_q[VALUE_BITS-2:0], rem_ge};
				fire  = busy_q && (bit_cnt_q == BIT_LAST);
			end
			RADIX_BIN: begin
				digit = {3'b000, work_q[0]};
				quot  = work_q >> 1;
				fire  = busy_q;
			end
			default: begin
				digit = work_q[3:0];
				quot  = work_q >> 4;
				fire  = busy_q;
			end
		endcase
		more = (quot != '0) && (addr_q != ADDR_LAST);
	end

	always_comb begin
		status.we    = fire;
		status.addr  = addr_q;
		status.digit = digit;
		status.done  = fire && !more;
	end

	// Load on start, shift while busy, step the digit address per digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			bit_cnt_q <= '0;
			addr_q    <= '0;
			radix_q   <= RADIX_HEX;
		end else if (start) begin
			busy_q    <= 1'b1;
			bit_cnt_q <= '0;
			addr_q    <= '0;
			radix_q   <= radix;
		end else if (busy_q) begin
			if (fire) begin
				bit_cnt_q <= '0;
				addr_q    <= addr_q + 1'b1;
				if (!more) begin
					busy_q <= 1'b0;
				end
			end else begin
				bit_cnt_q <= bit_cnt_q + 1'b1;
			end
		end
	end

	// Working value and partial remainder
	always_ff @(posedge clk) begin
		if (start) begin
			work_q <= start_value;
			rem_q  <= 4'd0;
		end else if (busy_q) begin
			work_q <= quot;
			rem_q  <= fire ? 4'd0 : rem_nxt;
		end
	end

endmodule

### sv/arc_digit_buf.sv
// Digit buffer: stores digits least significant first, emits them most significant first.
`timescale 1ns / 1ps

module arc_digit_buf import arc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  gen_status_t status,
	input  logic        ovf,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	logic [3:0]        mem [DIGIT_DEPTH];
	logic [ADDR_W-1:0] rd_ptr_q;
	logic              emitting_q;
	logic              pending_q;
	logic              pend_last_q;
	logic [3:0]        rd_data_q;
	logic              out_valid_q;
	out_item_t         out_q;
	logic              out_take;
	logic              issue;

	assign out_take  = out_valid_q && !out_stall;
	assign issue     = emitting_q && !pending_q && (!out_valid_q || out_take);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Write generated digits, read one back per issue
	always_ff @(posedge clk) begin
		if (status.we) begin
			mem[status.addr] <= status.digit;
		end
		if (issue) begin
			rd_data_q   <= mem[rd_ptr_q];
			pend_last_q <= (rd_ptr_q == '0);
		end
	end

	// Walk the read pointer down from the top digit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitting_q <= 1'b0;
			pending_q  <= 1'b0;
			rd_ptr_q   <= '0;
		end else begin
			pending_q <= issue;
			if (status.done) begin
				emitting_q <= 1'b1;
				rd_ptr_q   <= status.addr;
			end else if (issue) begin
				rd_ptr_q <= rd_ptr_q - 1'b1;
				if (rd_ptr_q == '0) begin
					emitting_q <= 1'b0;
				end
			end
		end
	end

	// Hold the output transaction until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pending_q) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pending_q) begin
			out_q.out_char   <= glyph(rd_data_q);
			out_q.out_last   <= pend_last_q;
			out_q.overflowed <= ovf;
		end
	end

endmodule
